/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* rtl/erd_pkg.sv */
package erd_pkg;

	// Frame and window limits.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int MAX_RADIUS = 3;

	// Field and register widths.
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int FW_W      = 11;
	localparam int FH_W      = 13;
	localparam int RAD_W     = 2;
	localparam int ROW_W     = 13;
	localparam int OUT_ROW_W = 12;
	localparam int PIX_W     = 8;
	localparam int RUN_W     = 3;
	localparam int POS_W     = ROW_W + FW_W;
	localparam int LAG_W     = RAD_W + FW_W;
	localparam int RES_W     = PIX_W + OUT_ROW_W + COL_W;
	localparam int DATA_OUT_W = ((RES_W + 7) / 8) * 8;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_RADIUS       = 2'd2
	} cfg_reg_t;

	localparam logic [FW_W-1:0]  FW_RESET  = 11'd640;
	localparam logic [FH_W-1:0]  FH_RESET  = 13'd480;
	localparam logic [RAD_W-1:0] RAD_RESET = 2'd1;

	// Pixel codes and run saturation.
	localparam logic [PIX_W-1:0] PIX_FG = 8'd255;
	localparam logic [PIX_W-1:0] PIX_BG = 8'd0;
	localparam logic             OPC_PIXEL = 1'b0;
	localparam logic [RUN_W-1:0] RUN_MAX = 3'd7;

	// Position recompute sequence after reset or a register write.
	typedef enum logic [1:0] {
		INIT_DONE = 2'd0,
		INIT_ADD  = 2'd1,
		INIT_MUL  = 2'd2
	} init_state_t;

	// Output queue.
	localparam int OFIFO_DEPTH = 4;
	localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
	localparam int OFIFO_CNT_W = OFIFO_AW + 1;

	// Per-word control carried from the position stage into the run stage.
	typedef struct packed {
		logic             valid;
		logic [COL_W-1:0] col;
		logic             fg;
		logic             first_row;
		logic             in_frame;
		logic             col0;
		logic             emit;
		logic             last;
		logic [OUT_ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
	} pix_ctl_t;

	// One result word.
	typedef struct packed {
		logic [COL_W-1:0]     col;
		logic [OUT_ROW_W-1:0] row;
		logic [PIX_W-1:0]     value;
		logic                 last;
	} result_t;

	function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
		return (v >= RUN_MAX) ? RUN_MAX : v + RUN_W'(1);
	endfunction

endpackage

/* rtl/binary_erosion_square_window_core.sv */
// Channel   Direction  tdata                                     tuser / tlast
// s_axis    in         [7:0] pixel_value                         tuser: opcode
// m_axis    out        [7:0] out_value [19:8] out_row [29:20] out_col  tlast: last
// cfg       in         write enable, register index, write data  none
//
// One word per cycle sustained while input is not held off. A word is pushed into
// the output queue in the cycle after it is taken, behind the registered read of
// the column run memory. Results trail the input by radius*frame_width+radius words.
// After reset and after every register write, input is held off while the raster
// position is rebuilt by one multiply (INIT_MUL) and then one add (INIT_ADD).
// Input also stalls on cfg_we and when the four-entry output queue could overflow.
module binary_erosion_square_window_core import erd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel_value
	input  logic                  s_axis_tuser,   // [0] opcode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [DATA_OUT_W-1:0] m_axis_tdata,   // [7:0] out_value, [19:8] out_row,
	                                              // [29:20] out_col
	output logic                  m_axis_tlast
);

	logic                   accept;
	logic                   busy;
	logic [COL_W-1:0]       rd_addr;
	logic [RAD_W-1:0]       radius_eff;
	pix_ctl_t               ctl_s1;
	logic                   res_valid;
	result_t                res;
	result_t                head;
	logic [OFIFO_CNT_W-1:0] fifo_cnt;

	// Take a word only if the queue can hold every result already in flight.
	assign s_axis_tready = !busy && !cfg_we
		&& ((fifo_cnt + OFIFO_CNT_W'(ctl_s1.valid)) < OFIFO_CNT_W'(OFIFO_DEPTH));
	assign accept = s_axis_tvalid && s_axis_tready;

	erd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.accept      (accept),
		.opcode      (s_axis_tuser),
		.pixel_value (s_axis_tdata),
		.busy        (busy),
		.rd_addr     (rd_addr),
		.radius_eff  (radius_eff),
		.ctl_s1      (ctl_s1)
	);

	erd_run u_run (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (accept),
		.rd_addr    (rd_addr),
		.radius_eff (radius_eff),
		.ctl_s1     (ctl_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	erd_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (m_axis_tvalid && m_axis_tready),
		.valid     (m_axis_tvalid),
		.data      (head),
		.count     (fifo_cnt)
	);

	// Pack the head word.
	assign m_axis_tdata = DATA_OUT_W'({head.col, head.row, head.value});
	assign m_axis_tlast = head.last;

endmodule

/* rtl/erd_ctrl.sv */
module erd_ctrl import erd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  accept,
	input  logic                  opcode,
	input  logic [PIX_W-1:0]      pixel_value,
	output logic                  busy,
	output logic [COL_W-1:0]      rd_addr,
	output logic [RAD_W-1:0]      radius_eff,
	output pix_ctl_t              ctl_s1
);

	logic [FW_W-1:0]   width_q;
	logic [FH_W-1:0]   height_q;
	logic [RAD_W-1:0]  radius_q;
	logic [ROW_W-1:0]  in_row_q;
	logic [COL_W-1:0]  in_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  prod_q;
	logic [LAG_W-1:0]  lag_q;
	init_state_t       init_q;
	init_state_t       init_d;

	logic [FW_W-1:0]  w_eff;
	logic [FH_W-1:0]  h_eff;
	logic [COL_W-1:0] col;
	logic             in_frame;
	logic             fg;
	logic             emit;
	logic             last;
	logic [FW_W-1:0]  in_col_inc;
	logic [FW_W-1:0]  out_col_inc;

	// Clamp the registers to their usable ranges.
	always_comb begin
		if (width_q == '0) begin
			w_eff = FW_W'(1);
		end else if (width_q > FW_W'(MAX_WIDTH)) begin
			w_eff = FW_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = FH_W'(1);
		end else if (height_q > FH_W'(MAX_HEIGHT)) begin
			h_eff = FH_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		radius_eff = (radius_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_q;
	end

	// Decode the incoming word against the current positions.
	always_comb begin
		col         = (FW_W'(in_col_q) < w_eff) ? in_col_q : COL_W'(w_eff - FW_W'(1));
		in_frame    = in_row_q < h_eff;
		fg          = in_frame && (opcode == OPC_PIXEL) && (pixel_value == PIX_FG);
		emit        = pos_q >= POS_W'(lag_q);
		last        = emit && ((14'(out_row_q) + 14'd1) >= 14'(h_eff))
			&& ((FW_W'(out_col_q) + FW_W'(1)) >= w_eff);
		in_col_inc  = FW_W'(in_col_q) + FW_W'(1);
		out_col_inc = FW_W'(out_col_q) + FW_W'(1);
	end

	assign rd_addr = col;

	// Recompute sequence: a register write restarts it, otherwise it runs to done.
	always_comb begin
		if (cfg_we) begin
			init_d = INIT_MUL;
		end else begin
			unique case (init_q)
				INIT_MUL:  init_d = INIT_ADD;
				INIT_ADD:  init_d = INIT_DONE;
				INIT_DONE: init_d = INIT_DONE;
				default:   init_d = INIT_MUL;
			endcase
		end
	end

	// Input is held off until the position has been rebuilt.
	always_comb begin
		busy = init_q != INIT_DONE;
	end

	// Registers, recompute sequence and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= FW_RESET;
			height_q  <= FH_RESET;
			radius_q  <= RAD_RESET;
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			pos_q     <= '0;
			init_q    <= INIT_MUL;
		end else begin
			init_q <= init_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FRAME_WIDTH:  width_q  <= cfg_wdata[FW_W-1:0];
					REG_FRAME_HEIGHT: height_q <= cfg_wdata[FH_W-1:0];
					REG_RADIUS:       radius_q <= cfg_wdata[RAD_W-1:0];
					default: ;
				endcase
			end else if (init_q == INIT_ADD) begin
				pos_q <= prod_q + POS_W'(in_col_q);
			end else if (accept) begin
				if (last) begin
					in_row_q  <= '0;
					in_col_q  <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
					pos_q     <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
					if (in_col_inc >= w_eff) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + ROW_W'(1);
					end else begin
						in_col_q <= in_col_inc[COL_W-1:0];
					end
					if (emit) begin
						if (out_col_inc >= w_eff) begin
							out_col_q <= '0;
							out_row_q <= out_row_q + ROW_W'(1);
						end else begin
							out_col_q <= out_col_inc[COL_W-1:0];
						end
					end
				end
			end
		end
	end

	// Row base product and lag for the recompute sequence.
	always_ff @(posedge clk) begin
		if (init_q == INIT_MUL) begin
			prod_q <= POS_W'(in_row_q) * POS_W'(w_eff);
			lag_q  <= LAG_W'(radius_eff) * LAG_W'(w_eff) + LAG_W'(radius_eff);
		end
	end

	// Stage 1 valid bit and payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			if (accept) begin
				ctl_s1.col       <= col;
				ctl_s1.fg        <= fg;
				ctl_s1.first_row <= in_row_q == '0;
				ctl_s1.in_frame  <= in_frame;
				ctl_s1.col0      <= in_col_q == '0;
				ctl_s1.emit      <= emit;
				ctl_s1.last      <= last;
				ctl_s1.out_row   <= out_row_q[OUT_ROW_W-1:0];
				ctl_s1.out_col   <= out_col_q;
			end
		end
	end

endmodule

/* rtl/erd_run.sv */
module erd_run import erd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [COL_W-1:0] rd_addr,
	input  logic [RAD_W-1:0] radius_eff,
	input  pix_ctl_t         ctl_s1,
	output logic             res_valid,
	output result_t          res
);

	logic [RUN_W-1:0] mem [MAX_WIDTH];
	logic [RUN_W-1:0] rdata_s1;
	logic             fwd_s1;
	logic [RUN_W-1:0] fwd_data_s1;
	logic [RUN_W-1:0] row_run_q;

	logic             wr_en;
	logic [RUN_W-1:0] span;
	logic [RUN_W-1:0] stored;
	logic [RUN_W-1:0] vrun;
	logic [RUN_W-1:0] prev_h;
	logic [RUN_W-1:0] hrun;

	// Vertical and horizontal run update for the word in stage 1.
	always_comb begin
		wr_en = ctl_s1.valid && ctl_s1.in_frame;
		span  = RUN_W'({radius_eff, 1'b1});
		if (ctl_s1.first_row) begin
			stored = '0;
		end else if (fwd_s1) begin
			stored = fwd_data_s1;
		end else begin
			stored = rdata_s1;
		end
		vrun   = ctl_s1.fg ? sat_inc(stored) : '0;
		prev_h = ctl_s1.col0 ? '0 : row_run_q;
		hrun   = (vrun >= span) ? sat_inc(prev_h) : '0;
	end

	// Column run memory: read for the next word, write back this one.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[ctl_s1.col] <= vrun;
		end
	end

	// The memory returns old data when the word behind reads the column
	// written in this cycle, so the new run is forwarded around it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1 <= 1'b0;
		end else if (rd_en) begin
			fwd_s1 <= wr_en && (ctl_s1.col == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_s1 <= vrun;
		end
	end

	// Horizontal run, cleared at frame end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_run_q <= '0;
		end else if (ctl_s1.valid) begin
			row_run_q <= ctl_s1.last ? '0 : hrun;
		end
	end

	// Result word.
	always_comb begin
		res_valid = ctl_s1.valid && ctl_s1.emit;
		res.value = ((hrun >= span) && ctl_s1.in_frame) ? PIX_FG : PIX_BG;
		res.row   = ctl_s1.out_row;
		res.col   = ctl_s1.out_col;
		res.last  = ctl_s1.last;
	end

endmodule

/* rtl/erd_ofifo.sv */
module erd_ofifo import erd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  result_t                push_data,
	input  logic                   pop,
	output logic                   valid,
	output result_t                data,
	output logic [OFIFO_CNT_W-1:0] count
);

	result_t                fifo_q [OFIFO_DEPTH];
	logic [OFIFO_AW-1:0]    wr_ptr_q;
	logic [OFIFO_AW-1:0]    rd_ptr_q;
	logic [OFIFO_CNT_W-1:0] cnt_q;

	assign valid = cnt_q != '0;
	assign data  = fifo_q[rd_ptr_q];
	assign count = cnt_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OFIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OFIFO_AW'(1);
			end
			cnt_q <= cnt_q + OFIFO_CNT_W'(push) - OFIFO_CNT_W'(pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/erd_chk.sv */
`include "assert_macros.svh"

module erd_chk import erd_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [DATA_OUT_W-1:0] m_axis_tdata,
	input logic                  m_axis_tlast
);

	// An eroded pixel is either full foreground or background.
	`ASSERT_IMPLY(a_value_binary, clk, arst_n, m_axis_tvalid, (m_axis_tdata[PIX_W-1:0] == PIX_FG) || (m_axis_tdata[PIX_W-1:0] == PIX_BG), "output pixel is neither 0 nor 255")

	// Padding above the packed fields stays zero.
	`ASSERT_IMPLY(a_pad_zero, clk, arst_n, m_axis_tvalid, m_axis_tdata[DATA_OUT_W-1:RES_W] == '0, "output padding bits are not zero")

	// A register write holds off input while the position is rebuilt.
	`ASSERT_NEXT(a_cfg_holdoff, clk, arst_n, cfg_we, !s_axis_tready, "input taken right after a register write")

	// A stalled output word holds.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output word changed")

endmodule

bind binary_erosion_square_window_core erd_chk u_erd_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_we        (cfg_we),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
